// ----- sv/bdut_pkg.sv -----
package bdut_pkg;

  localparam int TableSize = 1024;
  localparam int SlotW = 10;
  localparam int LenW = 11;
  localparam int ProbeLimit = 50;
  localparam int ProbeW = 6;

  localparam logic [1:0] CMD_SEARCH = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED = 2'd1;
  localparam logic [1:0] MARK_TOMB = 2'd2;

  localparam logic [2:0] ST_FOUND = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_DELETED = 3'd3;
  localparam logic [2:0] ST_FILL = 3'd4;
  localparam logic [2:0] ST_PROBE = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the item, key := var_index
    logic hash;       // register the hash of the current key
    logic mod_start;  // begin the modulo
    logic mod_step;   // one restoring step of the modulo
    logic rd;         // read the slot at the computed index
    logic advance;    // key := next key
    logic wr_used;    // write the item into the slot
    logic wr_tomb;    // mark the slot as a tombstone
    logic clr;        // clearing pass write of one mark
    logic count;      // bump the insert counter
  } bdut_cmd_t;

  typedef struct packed {
    logic used;
    logic empty;
    logic key_match;
    logic handle_match;
    logic fill_over;
    logic mod_done;
    logic clr_last;
  } bdut_stat_t;

  // Absolute value of the signed hash sum, with the most negative value saturated.
  function automatic logic [30:0] hash_abs(input logic [31:0] s);
    logic [31:0] n;
    n = 32'd0 - s;
    if (!s[31]) hash_abs = s[30:0];
    else if (s == 32'h8000_0000) hash_abs = 31'h7FFF_FFFF;
    else hash_abs = n[30:0];
  endfunction

endpackage

// ----- sv/bdut_datapath.sv -----
module bdut_datapath import bdut_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  bdut_cmd_t          cmd,
  output bdut_stat_t         stat,
  input  logic [1:0]         in_command,
  input  logic [15:0]        in_var_index,
  input  logic [31:0]        in_high_child,
  input  logic [31:0]        in_low_child,
  input  logic [31:0]        in_node_handle,
  input  logic [LenW-1:0]    len_eff,
  output logic [1:0]         op,
  output logic [SlotW-1:0]   slot_idx,
  output logic [31:0]        rd_handle
);

  logic [15:0] var_r;
  logic [31:0] hi_r, lo_r, hd_r, key_r, ins_cnt_r;
  logic [1:0]  op_r;
  logic [30:0] hash_r;
  logic [4:0]  mstep_r;
  logic [LenW-1:0] rem_r;
  logic [SlotW-1:0] idx, clr_r;
  logic [1:0]  mark_r;
  logic [15:0] rvar_r;
  logic [31:0] rhi_r, rlo_r, rhd_r;

  logic [1:0]  mark_mem [TableSize];
  logic [15:0] var_mem  [TableSize];
  logic [31:0] hi_mem   [TableSize];
  logic [31:0] lo_mem   [TableSize];
  logic [31:0] hd_mem   [TableSize];

  logic [31:0] sum;
  logic [LenW:0] trial;
  logic [27:0] fill_prod;
  logic [11:0] fill_lim;

  assign sum = key_r + {hi_r[30:0], 1'b0} + lo_r + {{4{hi_r[31]}}, hi_r[31:4]}
             + {{5{lo_r[31]}}, lo_r[31:5]};
  assign trial = {rem_r, hash_r[mstep_r]} - {1'b0, len_eff};
  // length * 8 / 10 == (4 * length) / 5; the divide by five is a multiply by 13108 / 2^16,
  // which is exact for every length up to the table size.
  assign fill_prod = 28'(len_eff) * 28'd52432;
  assign fill_lim = fill_prod[27:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_cnt_r <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.count) ins_cnt_r <= ins_cnt_r + 32'd1;
      if (cmd.clr) clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_command;
      var_r <= in_var_index;
      hi_r <= in_high_child;
      lo_r <= in_low_child;
      hd_r <= in_node_handle;
      key_r <= {16'd0, in_var_index};
    end else if (cmd.advance) begin
      key_r <= key_r + {key_r[29:0], 2'b00} + hi_r + {lo_r[30:0], 1'b0};
    end
    if (cmd.hash) hash_r <= hash_abs(sum);
    if (cmd.mod_start) begin
      rem_r <= '0;
      mstep_r <= 5'd30;
    end else if (cmd.mod_step) begin
      rem_r <= trial[LenW] ? {rem_r[LenW-2:0], hash_r[mstep_r]} : trial[LenW-1:0];
      mstep_r <= mstep_r - 5'd1;
    end
  end

  assign idx = rem_r[SlotW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clr) mark_mem[clr_r] <= MARK_EMPTY;
    else if (cmd.wr_used) mark_mem[idx] <= MARK_USED;
    else if (cmd.wr_tomb) mark_mem[idx] <= MARK_TOMB;
    if (cmd.wr_used) begin
      var_mem[idx] <= var_r;
      hi_mem[idx] <= hi_r;
      lo_mem[idx] <= lo_r;
      hd_mem[idx] <= hd_r;
    end
    if (cmd.rd) begin
      mark_r <= mark_mem[idx];
      rvar_r <= var_mem[idx];
      rhi_r <= hi_mem[idx];
      rlo_r <= lo_mem[idx];
      rhd_r <= hd_mem[idx];
    end
  end

  assign stat.used = (mark_r == MARK_USED);
  assign stat.empty = (mark_r == MARK_EMPTY);
  assign stat.key_match = (rvar_r == var_r) && (rhi_r == hi_r) && (rlo_r == lo_r);
  assign stat.handle_match = (rhd_r == hd_r);
  assign stat.fill_over = (ins_cnt_r > {20'd0, fill_lim});
  assign stat.mod_done = (mstep_r == 5'd0);
  assign stat.clr_last = (clr_r == SlotW'(TableSize - 1));

  assign op = op_r;
  assign slot_idx = idx;
  assign rd_handle = rhd_r;

endmodule

// ----- sv/bdut_ctrl.sv -----
module bdut_ctrl import bdut_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  bdut_stat_t       stat,
  input  logic [1:0]       op,
  output bdut_cmd_t        cmd,
  output logic             done,
  output logic [2:0]       status
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_HASH  = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_EVAL  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [ProbeW-1:0] probe_r, probe_nxt;
  logic last_probe;

  assign last_probe = (probe_r == ProbeW'(ProbeLimit));

  always_comb begin
    state_nxt = state_r;
    probe_nxt = probe_r;
    cmd = '0;
    done = 1'b0;
    status = ST_PROBE;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          probe_nxt = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (op == CMD_INSERT) begin
          cmd.count = 1'b1;
          if (stat.fill_over) begin
            done = 1'b1;
            status = ST_FILL;
            state_nxt = S_IDLE;
          end else state_nxt = S_HASH;
        end else if (op == CMD_SEARCH || op == CMD_DELETE) state_nxt = S_HASH;
        else begin
          done = 1'b1;
          status = ST_NOT_FOUND;
          state_nxt = S_IDLE;
        end
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        cmd.mod_start = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_done) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_HASH;
        cmd.advance = 1'b1;
        probe_nxt = probe_r + 1'b1;
        if (op == CMD_SEARCH && stat.used && stat.key_match) begin
          done = 1'b1;
          status = ST_FOUND;
        end else if (op == CMD_INSERT && !stat.used) begin
          done = 1'b1;
          status = ST_INSERTED;
          cmd.wr_used = 1'b1;
        end else if (op == CMD_DELETE && stat.used && stat.handle_match) begin
          done = 1'b1;
          status = ST_DELETED;
          cmd.wr_tomb = 1'b1;
        end else if (op != CMD_INSERT && stat.empty) begin
          done = 1'b1;
          status = ST_NOT_FOUND;
        end else if (last_probe) begin
          done = 1'b1;
          status = ST_PROBE;
        end
        if (done) begin
          cmd.advance = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      probe_r <= '0;
    end else begin
      state_r <= state_nxt;
      probe_r <= probe_nxt;
    end
  end

endmodule

// ----- sv/bdd_unique_table_engine.sv -----
// Unique table engine. After reset the block clears all 1024 slot marks, with busy
// high. A command is taken when start is high and busy is low; its single
// result appears on the out_ ports for one cycle with out_valid high and cannot be held
// off. Each probe runs a hash, a 31-step restoring modulo by the table length, a memory
// read and a decision; a command makes up to 51 probes, and a refused insert or an
// unused command is answered without a probe. table_length is written through the
// cfg_ channel, which is always ready; write it only while idle.
module bdd_unique_table_engine import bdut_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_var_index,
  input  logic [31:0] in_high_child,
  input  logic [31:0] in_low_child,
  input  logic [31:0] in_node_handle,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [9:0]  out_slot,
  output logic [31:0] out_found_handle,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  bdut_cmd_t cmd;
  bdut_stat_t stat;
  logic [LenW-1:0] len_r, len_eff;
  logic [1:0] op;
  logic [SlotW-1:0] slot_idx;
  logic [31:0] rd_handle;
  logic done;
  logic [2:0] status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) len_r <= LenW'(TableSize);
    else if (cfg_valid) len_r <= cfg_data;
  end

  always_comb begin
    if (len_r == '0) len_eff = LenW'(1);
    else if (len_r > LenW'(TableSize)) len_eff = LenW'(TableSize);
    else len_eff = len_r;
  end

  bdut_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat),
    .op(op), .cmd(cmd), .done(done), .status(status)
  );

  bdut_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_command(in_command), .in_var_index(in_var_index),
    .in_high_child(in_high_child), .in_low_child(in_low_child),
    .in_node_handle(in_node_handle), .len_eff(len_eff),
    .op(op), .slot_idx(slot_idx), .rd_handle(rd_handle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= done;
    if (done) begin
      out_status <= status;
      out_slot <= (status == ST_FOUND || status == ST_INSERTED || status == ST_DELETED)
                  ? slot_idx : '0;
      out_found_handle <= (status == ST_FOUND) ? rd_handle : '0;
    end
  end

endmodule

// ----- bench/bdut_checker.sv -----
`timescale 1ns / 1ps

module bdut_checker import bdut_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_var_index,
  input  logic [31:0] in_high_child,
  input  logic [31:0] in_low_child,
  input  logic [31:0] in_node_handle,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic [9:0]  out_slot,
  input  logic [31:0] out_found_handle,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [10:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [31:0] handle;
  } table_reply_t;

  logic [1:0]  mark_q [TableSize];
  logic [31:0] handle_q [TableSize];
  logic [15:0] var_q [TableSize];
  logic [31:0] high_q [TableSize];
  logic [31:0] low_q [TableSize];
  logic [31:0] inserts_seen;
  logic [10:0] length_reg;
  table_reply_t replies_due [$];

  assign pending = replies_due.size();

  function automatic logic [31:0] probe_hash(logic [31:0] k, logic [31:0] h, logic [31:0] l);
    logic [31:0] sum;
    sum = k + (h << 1) + l + 32'($signed(h) >>> 4) + 32'($signed(l) >>> 5);
    if (sum == 32'h8000_0000) return 32'h7FFF_FFFF;
    if (sum[31]) return 32'd0 - sum;
    return sum;
  endfunction

  // Runs one command against the shadow table and returns what the block should answer.
  function automatic table_reply_t run_table_command(logic [1:0] cmd, logic [15:0] vi,
                                                     logic [31:0] hi, logic [31:0] lo,
                                                     logic [31:0] hd);
    table_reply_t r;
    logic [31:0] len;
    logic [31:0] key;
    logic [31:0] old;
    int s;
    r = '{status: ST_PROBE, slot: '0, handle: '0};
    len = (length_reg == 0) ? 32'd1 : (length_reg > TableSize) ? 32'(TableSize) : 32'(length_reg);
    key = 32'(vi);
    if (cmd == CMD_INSERT) begin
      old = inserts_seen;
      inserts_seen = inserts_seen + 1;
      if (old > len * 8 / 10) begin
        r.status = ST_FILL;
        return r;
      end
    end else if (cmd != CMD_SEARCH && cmd != CMD_DELETE) begin
      r.status = ST_NOT_FOUND;
      return r;
    end
    for (int p = 0; p <= ProbeLimit; p++) begin
      s = int'(probe_hash(key, hi, lo) % len);
      if (cmd == CMD_SEARCH) begin
        if (mark_q[s] == MARK_USED && var_q[s] == vi && high_q[s] == hi && low_q[s] == lo) begin
          r = '{status: ST_FOUND, slot: s[9:0], handle: handle_q[s]};
          return r;
        end
        if (mark_q[s] == MARK_EMPTY) begin
          r.status = ST_NOT_FOUND;
          return r;
        end
      end else if (cmd == CMD_INSERT) begin
        if (mark_q[s] != MARK_USED) begin
          mark_q[s] = MARK_USED;
          handle_q[s] = hd;
          var_q[s] = vi;
          high_q[s] = hi;
          low_q[s] = lo;
          r.status = ST_INSERTED;
          r.slot = s[9:0];
          return r;
        end
      end else begin
        if (mark_q[s] == MARK_USED && handle_q[s] == hd) begin
          mark_q[s] = MARK_TOMB;
          r.status = ST_DELETED;
          r.slot = s[9:0];
          return r;
        end
        if (mark_q[s] == MARK_EMPTY) begin
          r.status = ST_NOT_FOUND;
          return r;
        end
      end
      key = key + (key << 2) + hi + (lo << 1);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < TableSize; i++) mark_q[i] = MARK_EMPTY;
      inserts_seen = '0;
      length_reg = 11'd1024;
      replies_due.delete();
      fail_count <= 0;
    end else begin
      // A result leaving in this cycle can only belong to an item taken earlier.
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result: status %0d slot %0d handle %h",
                                        out_status, out_slot, out_found_handle);
        end else begin
          want = replies_due.pop_front();
          if (want.status !== out_status || want.slot !== out_slot ||
              want.handle !== out_found_handle) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected status %0d slot %0d handle %h, got %0d %0d %h",
                       want.status, want.slot, want.handle,
                       out_status, out_slot, out_found_handle);
          end
        end
      end
      if (cfg_valid && cfg_ready) length_reg = cfg_data;
      if (start && !busy)
        replies_due.push_back(run_table_command(in_command, in_var_index, in_high_child,
                                                in_low_child, in_node_handle));
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb import bdut_pkg::*;;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int StallLimit = 20000;

  typedef struct {
    logic [15:0] vi;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] hd;
  } node_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [15:0] in_var_index;
  logic [31:0] in_high_child;
  logic [31:0] in_low_child;
  logic [31:0] in_node_handle;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [9:0]  out_slot;
  logic [31:0] out_found_handle;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;
  int          fail_count;
  int          pending;
  int          quiet_cycles;
  node_t       live_nodes [$];

  bdd_unique_table_engine DUT (.*);

  bdut_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: too long without any item, result or register write means a hang.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [15:0] vi, logic [31:0] hi,
                           logic [31:0] lo, logic [31:0] hd);
    start <= 1'b1;
    in_command <= cmd;
    in_var_index <= vi;
    in_high_child <= hi;
    in_low_child <= lo;
    in_node_handle <= hd;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender();
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Register writes happen only once every result is back and the block has settled.
  // The extra edge lets the checker record an item taken at the edge just gone.
  task automatic set_length(logic [10:0] len);
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0 && !busy);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    node_t n;
    int pick;
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35 || live_nodes.size() == 0) begin
        n.vi = $urandom();
        n.hi = $urandom();
        n.lo = $urandom();
        n.hd = $urandom();
        // Now and then reuse a key so duplicates pile up along one probe chain.
        if (live_nodes.size() > 0 && $urandom_range(0, 4) == 0) begin
          pick = $urandom_range(0, live_nodes.size() - 1);
          n.vi = live_nodes[pick].vi;
          n.hi = live_nodes[pick].hi;
          n.lo = live_nodes[pick].lo;
        end
        live_nodes.push_back(n);
        send_item(CMD_INSERT, n.vi, n.hi, n.lo, n.hd);
      end else if (roll < 95) begin
        pick = $urandom_range(0, live_nodes.size() - 1);
        n = live_nodes[pick];
        if ($urandom_range(0, 4) == 0) begin
          n.vi = $urandom();
          n.hd = $urandom();
        end
        if (roll < 65) begin
          send_item(CMD_SEARCH, n.vi, n.hi, n.lo, n.hd);
        end else begin
          send_item(CMD_DELETE, n.vi, n.hi, n.lo, n.hd);
          if (n.hd == live_nodes[pick].hd) live_nodes.delete(pick);
        end
      end else begin
        send_item(CMD_UNUSED, $urandom(), $urandom(), $urandom(), $urandom());
      end
      pause_sender();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_command <= CMD_SEARCH;
    in_var_index <= '0;
    in_high_child <= '0;
    in_low_child <= '0;
    in_node_handle <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A single slot: chains of used and deleted slots run into the probe limit.
    set_length(11'd1);
    send_item(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hA5A5_0001);
    send_item(CMD_SEARCH, 16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0);
    send_item(CMD_DELETE, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
    send_item(CMD_SEARCH, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
    send_item(CMD_DELETE, 16'h0000, 32'h0, 32'h0, 32'hA5A5_0001);
    send_item(CMD_SEARCH, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
    send_item(CMD_INSERT, 16'h0001, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_item(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_length(11'd0);
    send_item(CMD_SEARCH, 16'h1234, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_item(CMD_INSERT, 16'h1234, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);

    // Full length (a written length above the table size is clamped), with extreme child values.
    set_length(11'd2047);
    send_item(CMD_INSERT, 16'h0000, 32'h0000_0000, 32'h8000_0000, 32'h0);
    send_item(CMD_SEARCH, 16'h0000, 32'h0000_0000, 32'h8000_0000, 32'h0);
    send_item(CMD_INSERT, 16'h0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(CMD_SEARCH, 16'h0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0);
    send_item(CMD_DELETE, 16'h0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(CMD_SEARCH, 16'h0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0);
    send_item(CMD_DELETE, 16'h5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);

    random_phase(450);
    set_length(11'd1024);
    random_phase(250);
    set_length(11'd97);
    random_phase(200);
    set_length(11'd3);
    random_phase(60);
    set_length(11'd1000);
    random_phase(320);

    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (2000) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- bdd_unique_table_engine.f -----
sv/bdut_pkg.sv
sv/bdut_datapath.sv
sv/bdut_ctrl.sv
sv/bdd_unique_table_engine.sv
bench/bdut_checker.sv
bench/tb.sv
